[rtl/scht_pkg.sv]
// ============================================================================
// scht_pkg
// Shared constants and types for the segment/circle hit test pipeline.
// ============================================================================
package scht_pkg;

    // Radius field width (unsigned fixed point)
    localparam int RADIUS_BITS    = 24;
    // Result bus width: hit in bit 0, zero padding above
    localparam int OUT_TDATA_BITS = 8;

    // Which test decides the result
    localparam logic [1:0] SEL_START = 2'd0;
    localparam logic [1:0] SEL_END   = 2'd1;
    localparam logic [1:0] SEL_MID   = 2'd2;

    // Decision flags carried alongside the wide products
    typedef struct packed {
        logic [1:0] sel;
        logic       pt_hit;
    } scht_flags_t;

endpackage

[rtl/scht_mul.sv]
// ============================================================================
// scht_mul
// Two-stage unsigned multiplier built from four half-width partial products.
// Stage one registers the partial products, stage two registers their sum.
// ============================================================================
module scht_mul #(
    parameter int A_BITS = 33,
    parameter int B_BITS = 33
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [A_BITS-1:0]        a,
    input  logic [B_BITS-1:0]        b,
    output logic [A_BITS+B_BITS-1:0] p
);
    localparam int AL = A_BITS / 2;
    localparam int AH = A_BITS - AL;
    localparam int BL = B_BITS / 2;
    localparam int BH = B_BITS - BL;
    localparam int PB = A_BITS + B_BITS;

    logic [AL+BL-1:0] ll_reg, ll_next;
    logic [AL+BH-1:0] lh_reg, lh_next;
    logic [AH+BL-1:0] hl_reg, hl_next;
    logic [AH+BH-1:0] hh_reg, hh_next;
    logic [PB-1:0]    p_reg,  p_next;

    // Partial products of the operand halves
    always_comb begin
        ll_next = (AL+BL)'(a[AL-1:0])      * (AL+BL)'(b[BL-1:0]);
        lh_next = (AL+BH)'(a[AL-1:0])      * (AL+BH)'(b[B_BITS-1:BL]);
        hl_next = (AH+BL)'(a[A_BITS-1:AL]) * (AH+BL)'(b[BL-1:0]);
        hh_next = (AH+BH)'(a[A_BITS-1:AL]) * (AH+BH)'(b[B_BITS-1:BL]);
    end

    // Align and add the partial products
    always_comb begin
        p_next = PB'(ll_reg) + (PB'(lh_reg) << BL) + (PB'(hl_reg) << AL)
               + (PB'(hh_reg) << (AL + BL));
    end

    // Advance both stages together with the surrounding pipeline
    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            hh_reg <= hh_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

[rtl/segment_circle_hit_test_top.sv]
// ============================================================================
// segment_circle_hit_test_top
// Exact integer test of whether a line segment passes strictly inside a circle.
// ============================================================================
// Usage:
//   Input channel s_*: one query per transfer. s_tdata from bit 0 up holds
//   start_x, start_y, end_x, end_y, center_x, center_y (COORD_BITS each,
//   signed) and radius (24 bits, unsigned, RADIUS_FRAC_BITS fraction bits).
//   Result channel m_*: one transfer per query, hit in m_tdata bit 0.
//   Results leave in query order.
// Timing:
//   Each query passes through seven register stages (differences, squares,
//   sums, two partial-product multiplier stages, subtract, compare) before
//   m_tvalid rises. Throughput is one query per cycle while m_tready does
//   not stall the output; every stage takes a new query each time it advances.
// Reset:
//   aresetn low empties the pipeline; queries in flight are dropped.
// Backpressure:
//   While m_tvalid is high and m_tready low, the whole pipeline holds and
//   s_tready is low; nothing is lost or repeated.
// ============================================================================
module segment_circle_hit_test_top #(
    parameter int COORD_BITS       = 16,
    parameter int RADIUS_FRAC_BITS = 8
) (
    input  logic aclk,
    input  logic aresetn,
    // Query input
    input  logic s_tvalid,
    output logic s_tready,
    // start_x, start_y, end_x, end_y, center_x, center_y, radius, zero pad
    input  logic [((6*COORD_BITS+scht_pkg::RADIUS_BITS+7)/8)*8-1:0] s_tdata,
    // Result output
    output logic m_tvalid,
    input  logic m_tready,
    // hit, zero pad
    output logic [scht_pkg::OUT_TDATA_BITS-1:0] m_tdata
);
    import scht_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int D    = C + 1;               // coordinate difference
    localparam int S    = 2 * C + 1;           // sum of two squares
    localparam int DOTW = 2 * C + 2;           // signed dot product
    localparam int RB   = RADIUS_BITS;
    localparam int R2   = 2 * RB;              // radius squared
    localparam int F2   = 2 * RADIUS_FRAC_BITS;
    localparam int PW   = (S + F2 > R2) ? S + F2 : R2;
    localparam int LW   = (2 * S + F2 > R2 + S) ? 2 * S + F2 : R2 + S;

    // Pipeline control: every stage moves when the output can take data
    logic       adv;
    logic [5:0] vld_reg, vld_next;
    logic       m_tvalid_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign vld_next = {vld_reg[4:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg      <= vld_next;
            m_tvalid_reg <= vld_reg[5];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: field unpack and coordinate differences
    // ------------------------------------------------------------------
    logic signed [C-1:0] sx, sy, ex, ey, cx, cy;
    logic [RB-1:0]       rad;

    assign sx  = s_tdata[0*C +: C];
    assign sy  = s_tdata[1*C +: C];
    assign ex  = s_tdata[2*C +: C];
    assign ey  = s_tdata[3*C +: C];
    assign cx  = s_tdata[4*C +: C];
    assign cy  = s_tdata[5*C +: C];
    assign rad = s_tdata[6*C +: RB];

    logic signed [D-1:0] vx_reg, vy_reg, dx_reg, dy_reg, qx_reg, qy_reg;
    logic signed [D-1:0] vx_next, vy_next, dx_next, dy_next, qx_next, qy_next;
    logic [RB-1:0]       rad_reg;

    always_comb begin
        vx_next = D'(ex) - D'(sx);
        vy_next = D'(ey) - D'(sy);
        dx_next = D'(cx) - D'(sx);
        dy_next = D'(cy) - D'(sy);
        qx_next = D'(cx) - D'(ex);
        qy_next = D'(cy) - D'(ey);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            vx_reg  <= vx_next;
            vy_reg  <= vy_next;
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            qx_reg  <= qx_next;
            qy_reg  <= qy_next;
            rad_reg <= rad;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squares, cross products and radius squared
    // ------------------------------------------------------------------
    logic signed [2*D-1:0] p_vxvx, p_vyvy, p_vxdx, p_vydy;
    logic signed [2*D-1:0] p_dxdx, p_dydy, p_qxqx, p_qyqy;

    always_comb begin
        p_vxvx = vx_reg * vx_reg;
        p_vyvy = vy_reg * vy_reg;
        p_vxdx = vx_reg * dx_reg;
        p_vydy = vy_reg * dy_reg;
        p_dxdx = dx_reg * dx_reg;
        p_dydy = dy_reg * dy_reg;
        p_qxqx = qx_reg * qx_reg;
        p_qyqy = qy_reg * qy_reg;
    end

    logic [2*C-1:0]        sq_vx_reg, sq_vy_reg, sq_dx_reg, sq_dy_reg;
    logic [2*C-1:0]        sq_qx_reg, sq_qy_reg;
    logic signed [2*C:0]   xp_x_reg, xp_y_reg;
    logic [R2-1:0]         rad2_reg, rad2_next;

    assign rad2_next = R2'(rad_reg) * R2'(rad_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_vx_reg <= p_vxvx[2*C-1:0];
            sq_vy_reg <= p_vyvy[2*C-1:0];
            sq_dx_reg <= p_dxdx[2*C-1:0];
            sq_dy_reg <= p_dydy[2*C-1:0];
            sq_qx_reg <= p_qxqx[2*C-1:0];
            sq_qy_reg <= p_qyqy[2*C-1:0];
            xp_x_reg  <= p_vxdx[2*C:0];
            xp_y_reg  <= p_vydy[2*C:0];
            rad2_reg  <= rad2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: length squared, dot product, endpoint distances squared
    // ------------------------------------------------------------------
    logic [S-1:0]           len2_reg, len2_next, d2_reg, d2_next, e2_reg, e2_next;
    logic signed [DOTW-1:0] dot_reg, dot_next;
    logic [R2-1:0]          rad2_s3_reg;

    always_comb begin
        len2_next = S'(sq_vx_reg) + S'(sq_vy_reg);
        d2_next   = S'(sq_dx_reg) + S'(sq_dy_reg);
        e2_next   = S'(sq_qx_reg) + S'(sq_qy_reg);
        dot_next  = DOTW'(xp_x_reg) + DOTW'(xp_y_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            len2_reg    <= len2_next;
            d2_reg      <= d2_next;
            e2_reg      <= e2_next;
            dot_reg     <= dot_next;
            rad2_s3_reg <= rad2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: clamp decision and endpoint tests; wide products start
    // ------------------------------------------------------------------
    logic        at_start, at_end, hit_start, hit_end;
    scht_flags_t flags_next, flags_s4_reg, flags_s5_reg, flags_s6_reg;

    always_comb begin
        at_start  = (len2_reg == '0) || dot_reg[DOTW-1] || (dot_reg == '0);
        at_end    = (dot_reg[S-1:0] >= len2_reg);
        hit_start = (PW'(d2_reg) << F2) < PW'(rad2_s3_reg);
        hit_end   = (PW'(e2_reg) << F2) < PW'(rad2_s3_reg);
        if (at_start) begin
            flags_next.sel    = SEL_START;
            flags_next.pt_hit = hit_start;
        end else if (at_end) begin
            flags_next.sel    = SEL_END;
            flags_next.pt_hit = hit_end;
        end else begin
            flags_next.sel    = SEL_MID;
            flags_next.pt_hit = 1'b0;
        end
    end

    // Interior case products; a two-stage multiplier covers stages 4 and 5
    logic [2*S-1:0]  p_dl, p_dd;
    logic [R2+S-1:0] p_rl;

    scht_mul #(.A_BITS(S), .B_BITS(S)) u_mul_dl (
        .aclk (aclk),
        .en   (adv),
        .a    (d2_reg),
        .b    (len2_reg),
        .p    (p_dl)
    );

    scht_mul #(.A_BITS(S), .B_BITS(S)) u_mul_dd (
        .aclk (aclk),
        .en   (adv),
        .a    (dot_reg[S-1:0]),
        .b    (dot_reg[S-1:0]),
        .p    (p_dd)
    );

    scht_mul #(.A_BITS(R2), .B_BITS(S)) u_mul_rl (
        .aclk (aclk),
        .en   (adv),
        .a    (rad2_s3_reg),
        .b    (len2_reg),
        .p    (p_rl)
    );

    // ------------------------------------------------------------------
    // Stage 6: scaled squared distance numerator against radius term
    // ------------------------------------------------------------------
    logic [LW-1:0] lhs_reg, lhs_next, rhs_reg, rhs_next;

    always_comb begin
        lhs_next = LW'(p_dl - p_dd) << F2;
        rhs_next = LW'(p_rl);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            flags_s4_reg <= flags_next;
            flags_s5_reg <= flags_s4_reg;
            flags_s6_reg <= flags_s5_reg;
            lhs_reg      <= lhs_next;
            rhs_reg      <= rhs_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: final compare and output register
    // ------------------------------------------------------------------
    logic hit_reg, hit_next;

    always_comb begin
        unique case (flags_s6_reg.sel) inside
            SEL_START, SEL_END: hit_next = flags_s6_reg.pt_hit;
            SEL_MID:            hit_next = lhs_reg < rhs_reg;
            default:            hit_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hit_reg <= hit_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_BITS-1){1'b0}}, hit_reg};

endmodule

[rtl/scht_checker.sv]
// ============================================================================
// scht_checker
// Port-level checks for the segment/circle hit test, bound to the top level.
// ============================================================================
module scht_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [scht_pkg::OUT_TDATA_BITS-1:0] m_tdata
);
    import scht_pkg::*;

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Input is taken exactly when the output stage can move
    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not track output stall");

    // A stalled result holds its value
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // Only the hit bit may be set in a result
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_TDATA_BITS-1:1] == '0))
        else $error("result padding bits set");

    // No new input transfer while the output is stalled
    a_no_take_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !(s_tvalid && s_tready))
        else $error("input transfer taken during output stall");

endmodule

bind segment_circle_hit_test_top scht_checker u_scht_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[sim/segment_circle_hit_test_top_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// segment_circle_hit_test_top_test
// Self-checking bench for the segment/circle hit test pipeline: a queue of
// segment and circle queries feeds a stream driver, an exact wide-integer
// predictor computes each verdict on transfer, and a monitor compares every
// result against the oldest pending verdict. Both sides stall at random.
// ============================================================================
module segment_circle_hit_test_top_test;

    localparam int COORD_BITS       = 16;
    localparam int RADIUS_FRAC_BITS = 8;

    // One query as it sits on s_tdata, highest field first
    typedef struct packed {
        logic [scht_pkg::RADIUS_BITS-1:0] radius;
        logic signed [COORD_BITS-1:0]     center_y;
        logic signed [COORD_BITS-1:0]     center_x;
        logic signed [COORD_BITS-1:0]     end_y;
        logic signed [COORD_BITS-1:0]     end_x;
        logic signed [COORD_BITS-1:0]     start_y;
        logic signed [COORD_BITS-1:0]     start_x;
    } query_t;

    // Query waiting to be sent; drain_first holds it until all verdicts are back
    typedef struct {
        query_t q;
        bit     drain_first;
    } pending_t;

    logic   aclk     = 1'b0;
    logic   aresetn  = 1'b0;
    logic   s_tvalid = 1'b0;
    logic   s_tready;
    query_t s_query  = '0;
    logic   m_tvalid;
    logic   m_tready = 1'b0;
    logic [scht_pkg::OUT_TDATA_BITS-1:0] m_tdata;

    pending_t pending_queries[$];
    bit       expected_hits[$];
    int       accepted_count = 0;
    int       total_queries  = 0;
    int       mismatch_count = 0;
    int       send_gap       = 0;
    int       send_calm      = 0;
    int       ready_hold     = 0;
    int       ready_calm     = 0;

    int corner_vals[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

    segment_circle_hit_test_top #(
        .COORD_BITS      (COORD_BITS),
        .RADIUS_FRAC_BITS(RADIUS_FRAC_BITS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_query),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Exact verdict: nearest segment point strictly inside the circle
    function automatic bit segment_hits_circle(query_t q);
        longint sx = longint'(q.start_x);
        longint sy = longint'(q.start_y);
        longint ex = longint'(q.end_x);
        longint ey = longint'(q.end_y);
        longint cx = longint'(q.center_x);
        longint cy = longint'(q.center_y);
        longint vx, vy, dx, dy, px, py, dot, len2, d2;
        logic [127:0] rad2, lhs, rhs;
        vx   = ex - sx;
        vy   = ey - sy;
        dx   = cx - sx;
        dy   = cy - sy;
        dot  = vx * dx + vy * dy;
        len2 = vx * vx + vy * vy;
        rad2 = 128'(q.radius) * 128'(q.radius);
        if (len2 == 0 || dot <= 0 || dot >= len2) begin
            // clamped to an endpoint (or a degenerate segment): point test
            px  = (len2 == 0 || dot <= 0) ? dx : cx - ex;
            py  = (len2 == 0 || dot <= 0) ? dy : cy - ey;
            d2  = px * px + py * py;
            lhs = 128'(d2) << (2 * RADIUS_FRAC_BITS);
            rhs = rad2;
        end else begin
            // interior projection: scaled squared perpendicular distance
            d2  = dx * dx + dy * dy;
            lhs = (128'(d2) * 128'(len2) - 128'(dot) * 128'(dot))
                  << (2 * RADIUS_FRAC_BITS);
            rhs = rad2 * 128'(len2);
        end
        return lhs < rhs;
    endfunction

    // Idle length: mostly none or short, a few long, with calm stretches
    function automatic int pick_gap(inout int calm_left);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_left = $urandom_range(20, 100);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int near(int base, int span);
        return base + int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic add_query(input int sx, input int sy, input int ex, input int ey,
                             input int cx, input int cy, input int unsigned rad,
                             input bit drain);
        pending_t p;
        p.q.start_x     = 16'(sx);
        p.q.start_y     = 16'(sy);
        p.q.end_x       = 16'(ex);
        p.q.end_y       = 16'(ey);
        p.q.center_x    = 16'(cx);
        p.q.center_y    = 16'(cy);
        p.q.radius      = 24'(rad);
        p.drain_first   = drain;
        pending_queries.push_back(p);
        total_queries++;
    endtask

    // Driver: present queued queries, record verdicts on each transfer
    always @(posedge aclk) begin
        pending_t head;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_hits.push_back(segment_hits_circle(s_query));
                accepted_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_queries.size() == 0 ||
                             (pending_queries[0].drain_first &&
                              expected_hits.size() != 0)) begin
                    s_tvalid <= 1'b0;
                end else begin
                    head = pending_queries.pop_front();
                    s_query  <= head.q;
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap(send_calm);
                end
            end
        end
    end

    // Monitor: check each result transfer, toggle m_tready at random
    always @(posedge aclk) begin
        bit want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_hits.size() == 0) begin
                    $display("%0t: result with no query pending, actual %0h",
                             $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_hits.pop_front();
                    if (m_tdata !== {{(scht_pkg::OUT_TDATA_BITS-1){1'b0}}, want}) begin
                        $display("%0t: hit mismatch, expected %0h, actual %0h",
                                 $time, want, m_tdata);
                        mismatch_count++;
                    end
                end
            end
            if (ready_hold > 0) begin
                ready_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                ready_hold = pick_gap(ready_calm);
            end
        end
    end

    // Stimulus and end of run
    initial begin
        int i, mode, span, bx, by, sx, sy;
        int unsigned rad;

        // zero-length segment: point test against the start
        add_query(0, 0, 0, 0, 3, 4, 6 << 8, 1'b0);
        add_query(0, 0, 0, 0, 3, 4, 5 << 8, 1'b0);
        // zero radius, centre on the start; sent only once the pipeline drains
        add_query(0, 0, 10, 0, 0, 0, 0, 1'b1);
        // projection before the start, just inside and on the circle
        add_query(0, 0, 10, 0, -3, 4, (5 << 8) + 1, 1'b0);
        add_query(0, 0, 10, 0, -3, 4, 5 << 8, 1'b0);
        // projection past the end
        add_query(0, 0, 10, 0, 13, 4, 5 << 8, 1'b0);
        add_query(0, 0, 10, 0, 13, 4, (5 << 8) + 1, 1'b0);
        // interior projection: exactly on, just inside, just outside
        add_query(-10, 0, 10, 0, 0, 5, 5 << 8, 1'b0);
        add_query(-10, 0, 10, 0, 0, 5, (5 << 8) + 1, 1'b0);
        add_query(-10, 0, 10, 0, 0, 5, (5 << 8) - 1, 1'b0);
        // projection landing exactly on each end
        add_query(0, 0, 10, 0, 0, 7, 8 << 8, 1'b0);
        add_query(0, 0, 10, 0, 10, 7, 7 << 8, 1'b0);
        // fractional radius
        add_query(-4, -4, 4, 4, 1, 0, 24'h0000B6, 1'b0);
        add_query(-4, -4, 4, 4, 1, 0, 24'h0000B5, 1'b0);
        // coordinate extremes
        add_query(-32768, -32768, 32767, 32767, 32767, -32768, 24'hFFFFFF, 1'b0);
        add_query(32767, 32767, -32768, -32768, 0, 0, 0, 1'b0);
        add_query(32767, 32767, -32768, -32768, 0, 0, 1, 1'b0);
        add_query(-32768, -32768, -32768, -32768, 32767, 32767, 24'hFFFFFF, 1'b0);
        add_query(32767, 32767, 32767, 32767, 32767, 32767, 24'hFFFFFF, 1'b0);
        add_query(-32768, 32767, 32767, -32768, -32768, -32768, 24'hFFFFFF, 1'b0);

        for (i = 0; i < 1000; i++) begin
            mode = $urandom_range(0, 9);
            if (mode <= 5) begin
                // clustered geometry so hits and misses both occur
                case ($urandom_range(0, 2))
                    0: span = 16;
                    1: span = 256;
                    default: span = 4096;
                endcase
                bx  = int'($urandom_range(0, 65535 - 2 * span)) - 32768 + span;
                by  = int'($urandom_range(0, 65535 - 2 * span)) - 32768 + span;
                sx  = near(bx, span);
                sy  = near(by, span);
                rad = $urandom_range(0, span * 3 * 256);
                if ($urandom_range(0, 7) == 0)
                    add_query(sx, sy, sx, sy, near(bx, span), near(by, span), rad,
                              i == 0 || $urandom_range(0, 149) == 0);
                else
                    add_query(sx, sy, near(bx, span), near(by, span),
                              near(bx, span), near(by, span), rad,
                              i == 0 || $urandom_range(0, 149) == 0);
            end else if (mode <= 8) begin
                // full-range coordinates
                rad = (mode == 8) ? $urandom_range(0, 4095) : $urandom_range(0, 24'hFFFFFF);
                add_query(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
                          int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
                          int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
                          rad, $urandom_range(0, 149) == 0);
            end else begin
                // coordinates at the corners of the range
                rad = ($urandom_range(0, 1) == 0) ? 24'hFFFFFF : $urandom_range(0, 24'hFFFFFF);
                add_query(corner_vals[$urandom_range(0, 6)], corner_vals[$urandom_range(0, 6)],
                          corner_vals[$urandom_range(0, 6)], corner_vals[$urandom_range(0, 6)],
                          corner_vals[$urandom_range(0, 6)], corner_vals[$urandom_range(0, 6)],
                          rad, $urandom_range(0, 149) == 0);
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for every query to go in and every verdict to come back
        while (accepted_count != total_queries) @(posedge aclk);
        while (expected_hits.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("segment_circle_hit_test_top regression: pass");
        end else begin
            $display("segment_circle_hit_test_top regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("segment_circle_hit_test_top regression: fail");
        $finish;
    end

endmodule

[sim.f]
rtl/scht_pkg.sv
rtl/scht_mul.sv
rtl/segment_circle_hit_test_top.sv
rtl/scht_checker.sv
sim/segment_circle_hit_test_top_test.sv
